FILE: design/orp_pkg.sv
// ----------------------------------------------------------------------------
// orp_pkg
// shared types and constants of the orbit representative search
// ----------------------------------------------------------------------------
package orp_pkg;

    localparam logic [1:0] OP_LOAD_MASK  = 2'd0;
    localparam logic [1:0] OP_LOAD_SHIFT = 2'd1;
    localparam logic [1:0] OP_LOAD_CHAR  = 2'd2;
    localparam logic [1:0] OP_QUERY      = 2'd3;

    localparam logic [1:0] REG_GROUP_SIZE  = 2'd0;
    localparam logic [1:0] REG_STAGE_COUNT = 2'd1;
    localparam logic [1:0] REG_FLIP_BITS   = 2'd2;
    localparam logic [1:0] REG_INV_MODE    = 2'd3;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_EVEN  = 2'd1;
    localparam logic [1:0] MODE_ODD   = 2'd2;
    // unassigned mode code, behaves as no inversion
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int CHAR_W = 18;
    localparam logic signed [CHAR_W-1:0] CH_MAX = 18'sd131071;
    localparam logic signed [CHAR_W-1:0] CH_MIN = -18'sd131072;
    localparam logic [16:0] NORM_MAX = 17'd65536;

    // controller to datapath
    typedef struct packed {
        logic init;        // load spin word into x and best, clear sum
        logic word_load;   // start an element: y <= x, read its tables
        logic stage_step;  // apply one delta-swap stage
        logic compare;     // compare plain image
        logic compare_flip;// compare flipped image
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
    } orp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sum_pos;
    } orp_status_t;

    function automatic logic signed [CHAR_W-1:0] neg_sat(
        input logic signed [CHAR_W-1:0] v);
        return (v == CH_MIN) ? CH_MAX : -v;
    endfunction

endpackage

FILE: design/orp_ctrl.sv
// ----------------------------------------------------------------------------
// orp_ctrl
// sequencer of one query: elements, stages, divide and square root
// ----------------------------------------------------------------------------
module orp_ctrl
    import orp_pkg::*;
#(
    parameter int GW = 8,
    parameter int SW = 4,
    parameter int MAX_GROUP = 256,
    parameter int MAX_STAGES = 16
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          query_start,
    input  logic [8:0]    group_size,
    input  logic [4:0]    stage_count,
    input  logic          inv_on,
    input  orp_status_t   status,
    input  logic          out_free,
    output orp_cmd_t      cmd,
    output logic [GW-1:0] elem,
    output logic [SW-1:0] stage,
    output logic          busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ELEM  = 3'd1;
    localparam logic [2:0] S_STAGE = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [GW:0]   elem_reg, elem_next;
    logic [SW:0]   stage_reg, stage_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [GW:0]   n_lim;
    logic [SW:0]   s_lim;

    always_comb
    begin
        if (group_size == 9'd0)
            n_lim = (GW+1)'(1);
        else if (32'(group_size) > MAX_GROUP)
            n_lim = (GW+1)'(MAX_GROUP);
        else
            n_lim = (GW+1)'(group_size);
        if (32'(stage_count) > MAX_STAGES)
            s_lim = (SW+1)'(MAX_STAGES);
        else
            s_lim = (SW+1)'(stage_count);
    end

    assign elem  = elem_reg[GW-1:0];
    assign stage = stage_reg[SW-1:0];
    assign busy  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (query_start)
                begin
                    cmd.init   = 1'b1;
                    elem_next  = '0;
                    state_next = S_ELEM;
                end
            end
            S_ELEM:
            begin
                // table reads for this element land next cycle
                cmd.word_load = 1'b1;
                stage_next    = '0;
                state_next    = S_STAGE;
            end
            S_STAGE:
            begin
                if (stage_reg == s_lim)
                    state_next = S_CMP;
                else
                begin
                    cmd.stage_step = 1'b1;
                    stage_next     = stage_reg + 1'b1;
                end
            end
            S_CMP:
            begin
                if (cnt_reg == 7'd0)
                begin
                    cmd.compare = 1'b1;
                    if (inv_on)
                        cnt_next = 7'd1;
                    else
                        cnt_next = 7'd2;
                end
                else
                begin
                    if (cnt_reg == 7'd1)
                        cmd.compare_flip = 1'b1;
                    cnt_next = 7'd0;
                    if (elem_reg + 1'b1 == n_lim)
                        state_next = S_DIV;
                    else
                    begin
                        elem_next  = elem_reg + 1'b1;
                        state_next = S_ELEM;
                    end
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 7'd0)
                begin
                    // nothing to divide when the sum is zero or negative
                    if (status.sum_pos)
                    begin
                        cmd.div_start = 1'b1;
                        cnt_next      = 7'd1;
                    end
                    else
                        state_next = S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == 7'd64)
                    begin
                        cnt_next   = '0;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == 7'd0)
                begin
                    cmd.sqrt_start = 1'b1;
                    cnt_next       = 7'd1;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == 7'd32)
                    begin
                        cnt_next   = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            elem_reg  <= '0;
            stage_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: design/orp_datapath.sv
// ----------------------------------------------------------------------------
// orp_datapath
// tables, delta-swap unit, minimum tracking, divider and square root
// ----------------------------------------------------------------------------
module orp_datapath
    import orp_pkg::*;
#(
    parameter int GW = 8,
    parameter int SW = 4,
    parameter int MAX_GROUP = 256,
    parameter int MAX_STAGES = 16,
    parameter int CHAR_FRAC_BITS = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load_en,
    input  logic [1:0]               operation,
    input  logic [7:0]               element_index,
    input  logic [3:0]               stage_index,
    input  logic [63:0]              mask_word,
    input  logic [5:0]               shift_amount,
    input  logic signed [CHAR_W-1:0] character_real,
    input  logic signed [CHAR_W-1:0] character_imag,
    input  logic [63:0]              spin_word,
    input  logic [8:0]               group_size,
    input  logic [63:0]              flip_bits,
    input  logic [1:0]               mode,
    input  orp_cmd_t                 cmd,
    input  logic [GW-1:0]            elem,
    input  logic [SW-1:0]            stage,
    output orp_status_t              status,
    output logic [63:0]              res_rep,
    output logic signed [CHAR_W-1:0] res_re,
    output logic signed [CHAR_W-1:0] res_im,
    output logic [16:0]              res_norm,
    output logic                     res_neg
);

    localparam int SUM_W = CHAR_W + GW + 2;

    // stage field of the address spans a full power of two
    logic [63:0]              mask_mem [MAX_GROUP*(2**SW)];
    logic [5:0]               shift_mem [2**SW];
    logic signed [CHAR_W-1:0] cre_mem [MAX_GROUP];
    logic signed [CHAR_W-1:0] cim_mem [MAX_GROUP];

    logic [63:0]              mask_rd_reg;
    logic [5:0]               shift_rd_reg;
    logic signed [CHAR_W-1:0] cre_reg, cim_reg;

    logic [63:0]              x_reg, y_reg, best_reg;
    logic signed [CHAR_W-1:0] bre_reg, bim_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [GW+SW-1:0]         wr_addr, rd_addr;

    assign wr_addr = {GW'(element_index), SW'(stage_index)};
    // mask read runs one stage ahead: while stage k is applied, k+1 is fetched
    assign rd_addr = cmd.word_load ? {elem, {SW{1'b0}}}
                                   : {elem, stage + 1'b1};

    always_ff @(posedge clk)
    begin
        if (load_en && operation == OP_LOAD_MASK
            && 32'(element_index) < MAX_GROUP && 32'(stage_index) < MAX_STAGES)
            mask_mem[wr_addr] <= mask_word;
        if (load_en && operation == OP_LOAD_SHIFT && 32'(stage_index) < MAX_STAGES)
            shift_mem[SW'(stage_index)] <= shift_amount;
        if (load_en && operation == OP_LOAD_CHAR && 32'(element_index) < MAX_GROUP)
        begin
            cre_mem[GW'(element_index)] <= character_real;
            cim_mem[GW'(element_index)] <= character_imag;
        end
        mask_rd_reg <= mask_mem[rd_addr];
        if (cmd.word_load)
        begin
            cre_reg <= cre_mem[elem];
            cim_reg <= cim_mem[elem];
        end
    end

    always_ff @(posedge clk)
    begin
        shift_rd_reg <= cmd.word_load ? shift_mem[{SW{1'b0}}]
                                      : shift_mem[stage + 1'b1];
    end

    logic [63:0] t, y_sw, yf;
    logic signed [CHAR_W-1:0] fre, fim;
    always_comb
    begin
        t    = ((y_reg >> shift_rd_reg) ^ y_reg) & mask_rd_reg;
        y_sw = y_reg ^ t ^ (t << shift_rd_reg);
        yf   = y_reg ^ flip_bits;
        fre  = (mode == MODE_ODD) ? neg_sat(cre_reg) : cre_reg;
        fim  = (mode == MODE_ODD) ? neg_sat(cim_reg) : cim_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            x_reg    <= spin_word;
            best_reg <= spin_word;
            bre_reg  <= (CHAR_FRAC_BITS >= CHAR_W-1) ? CH_MAX
                        : CHAR_W'(1 << CHAR_FRAC_BITS);
            bim_reg  <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.word_load)
            y_reg <= x_reg;
        else if (cmd.stage_step)
            y_reg <= y_sw;
        else if (cmd.compare)
        begin
            if (y_reg < best_reg)
            begin
                best_reg <= y_reg;
                bre_reg  <= cre_reg;
                bim_reg  <= cim_reg;
            end
            if (y_reg == x_reg)
                sum_reg <= sum_reg + SUM_W'(cre_reg);
        end
        else if (cmd.compare_flip)
        begin
            if (yf < best_reg)
            begin
                best_reg <= yf;
                bre_reg  <= fre;
                bim_reg  <= fim;
            end
            if (yf == x_reg)
                sum_reg <= sum_reg + SUM_W'(fre);
        end
    end

    // restoring divide: sum * 2^(32-F) / n (2n with inversion on), one quotient bit a cycle
    logic [63:0] quo_reg;
    logic [63:0] num_reg;
    logic [GW+2:0] rem_reg;
    logic [GW+1:0] den;
    logic [GW+3:0] rem_sh;
    logic [GW:0]   n_c;
    always_comb
    begin
        if (group_size == 9'd0)
            n_c = (GW+1)'(1);
        else if (32'(group_size) > MAX_GROUP)
            n_c = (GW+1)'(MAX_GROUP);
        else
            n_c = (GW+1)'(group_size);
        den    = (mode == MODE_NONE || mode == MODE_SPARE) ? {1'b0, n_c} : {n_c, 1'b0};
        rem_sh = {rem_reg, num_reg[63]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= (sum_reg > 0) ? (64'(sum_reg) << (32 - CHAR_FRAC_BITS)) : 64'd0;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (rem_sh >= (GW+4)'(den))
            begin
                rem_reg <= (GW+3)'(rem_sh - (GW+4)'(den));
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= (GW+3)'(rem_sh);
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    // digit-by-digit square root, two radicand bits a cycle
    logic [63:0] rad_reg;
    logic [33:0] root_reg;
    logic [35:0] srem_reg;
    logic [35:0] trial, srem_sh;
    always_comb
    begin
        srem_sh = {srem_reg[33:0], rad_reg[63:62]};
        trial   = {root_reg, 2'b01};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg  <= quo_reg;
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (srem_sh >= trial)
            begin
                srem_reg <= srem_sh - trial;
                root_reg <= {root_reg[32:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[32:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_rep  <= '0;
            res_re   <= '0;
            res_im   <= '0;
            res_neg  <= 1'b0;
            res_norm <= '0;
        end
        else if (cmd.out_load)
        begin
            res_rep  <= best_reg;
            res_re   <= bre_reg;
            res_im   <= bim_reg;
            res_neg  <= sum_reg < 0;
            // divide and root are skipped when the sum is not positive
            if (sum_reg <= 0)
                res_norm <= '0;
            else
                res_norm <= (root_reg > 34'(NORM_MAX)) ? NORM_MAX : root_reg[16:0];
        end
    end

    assign status.sum_pos = sum_reg > 0;

endmodule

FILE: design/orbit_representative_with_character.sv
// ----------------------------------------------------------------------------
// orbit_representative_with_character
// smallest image of a spin word over a delta-swap permutation group
// ----------------------------------------------------------------------------
// Load items (mask, shift, character) are written into the tables as they
// are accepted. A query runs over the elements up to the element count, and
// each element first reads its tables, then passes its stages through the
// shared delta-swap unit fed by one mask memory read a stage, and then takes
// two compare steps (the second also when inversion is off); then a 64-step
// divider and a 32-step square root produce the norm, both skipped when the
// character sum is zero or negative. One query is worked on at a time; the
// result sits in an output register so the next item is taken while it
// waits, and a query finishing while a result still waits holds until that
// result is taken.
module orbit_representative_with_character
    import orp_pkg::*;
#(
    parameter int MAX_GROUP = 256,
    parameter int MAX_STAGES = 16,
    parameter int CHAR_FRAC_BITS = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [63:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic [7:0]               element_index,
    input  logic [3:0]               stage_index,
    input  logic [63:0]              mask_word,
    input  logic [5:0]               shift_amount,
    input  logic signed [CHAR_W-1:0] character_real,
    input  logic signed [CHAR_W-1:0] character_imag,
    input  logic [63:0]              spin_word,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [63:0]              representative,
    output logic signed [CHAR_W-1:0] rep_character_real,
    output logic signed [CHAR_W-1:0] rep_character_imag,
    output logic [16:0]              norm,
    output logic                     norm_negative
);

    localparam int GW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    logic [8:0]  group_size_reg;
    logic [4:0]  stage_count_reg;
    logic [63:0] flip_bits_reg;
    logic [1:0]  inv_mode_reg;
    logic        out_valid_reg;

    orp_cmd_t      cmd;
    orp_status_t   status;
    logic [GW-1:0] elem;
    logic [SW-1:0] stage;
    logic          busy, in_acc, inv_on;

    assign in_ready = !busy;
    assign in_acc   = in_valid && in_ready;
    assign inv_on   = (inv_mode_reg == MODE_EVEN) || (inv_mode_reg == MODE_ODD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg  <= 9'd1;
            stage_count_reg <= '0;
            flip_bits_reg   <= '0;
            inv_mode_reg    <= MODE_NONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GROUP_SIZE:  group_size_reg  <= cfg_data[8:0];
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[4:0];
                REG_FLIP_BITS:   flip_bits_reg   <= cfg_data;
                REG_INV_MODE:    inv_mode_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end
    assign out_valid = out_valid_reg;

    orp_ctrl #(
        .GW(GW), .SW(SW), .MAX_GROUP(MAX_GROUP), .MAX_STAGES(MAX_STAGES)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .query_start(in_acc && operation == OP_QUERY),
        .group_size(group_size_reg), .stage_count(stage_count_reg),
        .inv_on(inv_on), .status(status),
        .out_free(!out_valid_reg || out_ready),
        .cmd(cmd), .elem(elem), .stage(stage), .busy(busy)
    );

    orp_datapath #(
        .GW(GW), .SW(SW), .MAX_GROUP(MAX_GROUP), .MAX_STAGES(MAX_STAGES),
        .CHAR_FRAC_BITS(CHAR_FRAC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .load_en(in_acc), .operation(operation),
        .element_index(element_index), .stage_index(stage_index),
        .mask_word(mask_word), .shift_amount(shift_amount),
        .character_real(character_real), .character_imag(character_imag),
        .spin_word(spin_word),
        .group_size(group_size_reg), .flip_bits(flip_bits_reg),
        .mode(inv_mode_reg),
        .cmd(cmd), .elem(elem), .stage(stage), .status(status),
        .res_rep(representative), .res_re(rep_character_real),
        .res_im(rep_character_imag), .res_norm(norm), .res_neg(norm_negative)
    );

    // no new item is taken while a query is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("item accepted during query");

    // a result appears only from the sequencer's output step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result without output step");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result overwritten");

endmodule

FILE: tb/orp_checker.sv
// ----------------------------------------------------------------------------
// orp_checker
// watches the item and result channels, predicts each query result and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module orp_checker
    import orp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [63:0]              cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               operation,
    input  logic [7:0]               element_index,
    input  logic [3:0]               stage_index,
    input  logic [63:0]              mask_word,
    input  logic [5:0]               shift_amount,
    input  logic signed [CHAR_W-1:0] character_real,
    input  logic signed [CHAR_W-1:0] character_imag,
    input  logic [63:0]              spin_word,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [63:0]              representative,
    input  logic signed [CHAR_W-1:0] rep_character_real,
    input  logic signed [CHAR_W-1:0] rep_character_imag,
    input  logic [16:0]              norm,
    input  logic                     norm_negative,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0]              rep;
        logic signed [CHAR_W-1:0] re;
        logic signed [CHAR_W-1:0] im;
        logic [16:0]              nrm;
        logic                     neg;
    } orbit_result_t;

    logic [63:0]              perm_masks [0:4095];
    logic [5:0]               stage_shifts [0:15];
    logic signed [CHAR_W-1:0] chars_re [0:255];
    logic signed [CHAR_W-1:0] chars_im [0:255];

    logic [8:0]  group_size_q;
    logic [4:0]  stage_count_q;
    logic [63:0] flip_bits_q;
    logic [1:0]  inv_mode_q;

    orbit_result_t orbit_results_q[$];
    int            errors;
    int            results_seen;

    function automatic longint unsigned root_floor(longint unsigned q);
        longint unsigned r;
        longint unsigned cand;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= q)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic signed [CHAR_W-1:0] negate_char(logic signed [CHAR_W-1:0] v);
        return (v == -18'sd131072) ? 18'sd131071 : -v;
    endfunction

    function automatic orbit_result_t reduce_word(logic [63:0] x);
        orbit_result_t            res;
        int                       n;
        int                       s;
        logic [1:0]               mode;
        logic [63:0]              y;
        logic [63:0]              yf;
        logic [63:0]              t;
        logic [5:0]               d;
        logic signed [CHAR_W-1:0] fre;
        logic signed [CHAR_W-1:0] fim;
        longint                   sum;
        longint unsigned          num;
        longint unsigned          den;
        longint unsigned          r;
        n = (group_size_q == 0) ? 1 : (group_size_q > 256 ? 256 : int'(group_size_q));
        s = (stage_count_q > 16) ? 16 : int'(stage_count_q);
        mode = (inv_mode_q == MODE_SPARE) ? MODE_NONE : inv_mode_q;
        res.rep = x;
        res.re = 18'sd65536;
        res.im = '0;
        sum = 0;
        for (int e = 0; e < n; e++)
        begin
            y = x;
            for (int k = 0; k < s; k++)
            begin
                d = stage_shifts[k];
                t = ((y >> d) ^ y) & perm_masks[e*16 + k];
                y = y ^ t ^ (t << d);
            end
            if (y < res.rep)
            begin
                res.rep = y;
                res.re = chars_re[e];
                res.im = chars_im[e];
            end
            if (y == x)
                sum += chars_re[e];
            if (mode != MODE_NONE)
            begin
                yf = y ^ flip_bits_q;
                fre = (mode == MODE_ODD) ? negate_char(chars_re[e]) : chars_re[e];
                fim = (mode == MODE_ODD) ? negate_char(chars_im[e]) : chars_im[e];
                if (yf < res.rep)
                begin
                    res.rep = yf;
                    res.re = fre;
                    res.im = fim;
                end
                if (yf == x)
                    sum += fre;
            end
        end
        res.neg = (sum < 0);
        res.nrm = '0;
        if (sum > 0)
        begin
            num = longint'(sum) << 32;
            den = longint'((mode != MODE_NONE) ? 2*n : n) << 16;
            r = root_floor(num / den);
            res.nrm = (r > 65536) ? NORM_MAX : r[16:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        orbit_result_t exp_res;
        if (!rst_n)
        begin
            group_size_q  <= 9'd1;
            stage_count_q <= '0;
            flip_bits_q   <= '0;
            inv_mode_q    <= MODE_NONE;
            errors        = 0;
            results_seen  = 0;
            orbit_results_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GROUP_SIZE:  group_size_q  <= cfg_data[8:0];
                    REG_STAGE_COUNT: stage_count_q <= cfg_data[4:0];
                    REG_FLIP_BITS:   flip_bits_q   <= cfg_data;
                    REG_INV_MODE:    inv_mode_q    <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_LOAD_MASK:  perm_masks[element_index*16 + stage_index] = mask_word;
                    OP_LOAD_SHIFT: stage_shifts[stage_index] = shift_amount;
                    OP_LOAD_CHAR:
                    begin
                        chars_re[element_index] = character_real;
                        chars_im[element_index] = character_imag;
                    end
                    OP_QUERY:      orbit_results_q.push_back(reduce_word(spin_word));
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (orbit_results_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result rep=%h", representative);
                end
                else
                begin
                    exp_res = orbit_results_q.pop_front();
                    if (exp_res.rep !== representative || exp_res.re !== rep_character_real
                        || exp_res.im !== rep_character_imag || exp_res.nrm !== norm
                        || exp_res.neg !== norm_negative)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: exp rep=%h re=%0d im=%0d norm=%0d neg=%0b",
                                     exp_res.rep, exp_res.re, exp_res.im, exp_res.nrm,
                                     exp_res.neg);
                            $display("          got rep=%h re=%0d im=%0d norm=%0d neg=%0b",
                                     representative, rep_character_real,
                                     rep_character_imag, norm, norm_negative);
                        end
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= orbit_results_q.size();
        checked    <= results_seen;
    end

endmodule

FILE: tb/orbit_representative_with_character_tb.sv
// ----------------------------------------------------------------------------
// orbit_representative_with_character_tb
// fills the permutation, shift and character tables, then runs directed and
// random items over several register settings, with random stalls in most
// ----------------------------------------------------------------------------
module orbit_representative_with_character_tb
    import orp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [1:0]               cfg_index = '0;
    logic [63:0]              cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               operation = OP_QUERY;
    logic [7:0]               element_index = '0;
    logic [3:0]               stage_index = '0;
    logic [63:0]              mask_word = '0;
    logic [5:0]               shift_amount = '0;
    logic signed [CHAR_W-1:0] character_real = '0;
    logic signed [CHAR_W-1:0] character_imag = '0;
    logic [63:0]              spin_word = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [63:0]              representative;
    logic signed [CHAR_W-1:0] rep_character_real;
    logic signed [CHAR_W-1:0] rep_character_imag;
    logic [16:0]              norm;
    logic                     norm_negative;

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int queries_sent = 0;
    int settings_used = 1;
    bit no_stall = 1'b0;

    always #5 clk = ~clk;

    orbit_representative_with_character u_dut (.*);

    orp_checker u_checker (.*);

    always @(posedge clk)
        out_ready <= no_stall || ($urandom_range(0, 99) >= 9);

    task automatic send_item(logic [1:0] op, logic [7:0] el, logic [3:0] st,
                             logic [63:0] m, logic [5:0] sh,
                             logic signed [CHAR_W-1:0] cr, logic signed [CHAR_W-1:0] ci,
                             logic [63:0] w);
        if (!no_stall && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        element_index  <= el;
        stage_index    <= st;
        mask_word      <= m;
        shift_amount   <= sh;
        character_real <= cr;
        character_imag <= ci;
        spin_word      <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (op == OP_QUERY)
            queries_sent++;
    endtask

    task automatic query(logic [63:0] w);
        send_item(OP_QUERY, 8'($urandom), 4'($urandom), {$urandom, $urandom},
                  6'($urandom), CHAR_W'($urandom), CHAR_W'($urandom), w);
    endtask

    task automatic load_char(logic [7:0] el, logic signed [CHAR_W-1:0] cr,
                             logic signed [CHAR_W-1:0] ci);
        send_item(OP_LOAD_CHAR, el, 4'($urandom), {$urandom, $urandom}, 6'($urandom),
                  cr, ci, {$urandom, $urandom});
    endtask

    function automatic logic [63:0] sparse_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: w = '0;
            1: w = w & {$urandom, $urandom} & {$urandom, $urandom};
            2: w = w & {$urandom, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic signed [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 5))
            0: return -18'sd131072;
            1: return 18'sd131071;
            2: return 18'sd65536;
            3: return -18'sd65536;
            default: return CHAR_W'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_spin();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return sparse_word();
            3: return ~sparse_word();
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_item();
        case ($urandom_range(0, 7))
            0: send_item(OP_LOAD_MASK, 8'($urandom), 4'($urandom), sparse_word(),
                         6'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                         {$urandom, $urandom});
            1: send_item(OP_LOAD_SHIFT, 8'($urandom), 4'($urandom), {$urandom, $urandom},
                         6'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                         {$urandom, $urandom});
            2: load_char(8'($urandom), pick_char(), pick_char());
            default: query(pick_spin());
        endcase
    endtask

    task automatic program_regs(logic [8:0] gs, logic [4:0] sc, logic [63:0] flip,
                                logic [1:0] mode);
        // wait for results still owed, then for any load still in flight
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GROUP_SIZE;
        cfg_data  <= 64'(gs);
        @(posedge clk);
        cfg_index <= REG_STAGE_COUNT;
        cfg_data  <= 64'(sc);
        @(posedge clk);
        cfg_index <= REG_FLIP_BITS;
        cfg_data  <= flip;
        @(posedge clk);
        cfg_index <= REG_INV_MODE;
        cfg_data  <= 64'(mode);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // define every entry a later query may use: all shifts, all stages
        // of element 0, stages 0..3 of elements 1..5, characters of 0..7
        for (int k = 0; k < 16; k++)
            send_item(OP_LOAD_SHIFT, 8'($urandom), 4'(k), {$urandom, $urandom},
                      6'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                      {$urandom, $urandom});
        for (int k = 0; k < 16; k++)
            send_item(OP_LOAD_MASK, 8'd0, 4'(k), sparse_word(), 6'($urandom),
                      CHAR_W'($urandom), CHAR_W'($urandom), {$urandom, $urandom});
        for (int e = 1; e < 6; e++)
            for (int k = 0; k < 4; k++)
                send_item(OP_LOAD_MASK, 8'(e), 4'(k), sparse_word(), 6'($urandom),
                          CHAR_W'($urandom), CHAR_W'($urandom), {$urandom, $urandom});
        for (int e = 0; e < 8; e++)
            load_char(8'(e), pick_char(), pick_char());

        // reset settings: one element, no stages
        load_char(8'd0, 18'sd65536, 18'sd0);
        query(64'd0);
        query('1);
        query(64'h8000_0000_0000_0000);
        load_char(8'd0, -18'sd131072, 18'sd131071);
        query({$urandom, $urandom});
        load_char(8'd0, 18'sd131071, -18'sd131072);
        query(64'h0000_0000_0000_0001);
        load_char(8'd0, 18'sd0, 18'sd5);
        query({$urandom, $urandom});

        // odd inversion with nothing flipped: the minimum character negates
        program_regs(9'd1, 5'd0, 64'd0, MODE_ODD);
        load_char(8'd0, -18'sd131072, -18'sd131072);
        query(64'h1234_5678_9abc_def0);
        program_regs(9'd1, 5'd0, '1, MODE_ODD);
        query('1);
        query(64'h7fff_ffff_ffff_ffff);
        program_regs(9'd1, 5'd0, 64'h8000_0000_0000_0001, MODE_EVEN);
        load_char(8'd0, 18'sd65536, 18'sd0);
        query(64'h8000_0000_0000_0001);
        query(64'd0);

        program_regs(9'd6, 5'd4, '1, MODE_EVEN);
        repeat (14) random_item();
        program_regs(9'd5, 5'd3, {$urandom, $urandom}, MODE_ODD);
        repeat (14) random_item();
        // out of range values clamp; mode 3 acts as no inversion
        program_regs(9'd0, 5'd31, 64'd0, MODE_SPARE);
        repeat (12) random_item();
        no_stall = 1'b1;
        program_regs(9'd8, 5'd0, sparse_word(), MODE_ODD);
        repeat (12) random_item();
        no_stall = 1'b0;
        program_regs(9'd6, 5'd2, {$urandom, $urandom}, MODE_EVEN);
        repeat (14) random_item();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d items (%0d queries) over %0d register settings",
                 items_sent, queries_sent, settings_used);
        $display("checked %0d results, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
